[hdl/map_iteration_period_finder_core_defines.svh]
// Assertion helpers shared by the period finder RTL.
`ifndef MAP_ITERATION_PERIOD_FINDER_CORE_DEFINES_SVH
`define MAP_ITERATION_PERIOD_FINDER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MIPF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MIPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mipf_pkg.sv]
`timescale 1ns / 1ps

package mipf_pkg;

    // Store depth default and Q4.28 format
    localparam int STORE_DEPTH_DEF = 64;
    localparam int FRAC_BITS       = 28;

    localparam logic signed [63:0] RND_HALF = 64'sh0000_0000_0800_0000;
    localparam logic signed [31:0] Q_ONE    = 32'sh1000_0000;
    localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAJ_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd3;

    localparam logic        MAP_SELECT_RST = 1'b1;
    localparam logic [6:0]  TRAJ_LEN_RST   = 7'd64;
    localparam logic [27:0] ITER_LIMIT_RST = 28'd100000000;
    localparam logic [27:0] TOLERANCE_RST  = 28'd268;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_RND1,
        ST_PREP,
        ST_MUL2,
        ST_RND2,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic rnd1;
        logic prep;
        logic mul2;
        logic rnd2;
        logic store;
        logic restart;
        logic end_close;
        logic end_limit;
        logic rd;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic close;
        logic iter_done;
        logic pass_full;
        logic out_free;
        logic emit_last;
    } status_t;

    // Round a full product to Q4.28 (half up, floor) and saturate
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
        logic signed [63:0] v;
        logic signed [35:0] q;
        v = p + RND_HALF;
        q = 36'(v >>> FRAC_BITS);
        if (q[35:31] == 5'b00000 || q[35:31] == 5'b11111) begin
            return q[31:0];
        end
        return q[35] ? Q_MIN : Q_MAX;
    endfunction

    // Saturating difference a - b
    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32] == d[31]) begin
            return d[31:0];
        end
        return d[32] ? Q_MIN : Q_MAX;
    endfunction

endpackage

[hdl/mipf_ctrl.sv]
`timescale 1ns / 1ps

module mipf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mipf_pkg::status_t  status,
    output mipf_pkg::cmd_t     cmd
);

    mipf_pkg::state_t state_reg;
    mipf_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mipf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            mipf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = mipf_pkg::ST_MUL1;
                end
            end
            mipf_pkg::ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = mipf_pkg::ST_RND1;
            end
            mipf_pkg::ST_RND1: begin
                cmd.rnd1   = 1'b1;
                state_next = mipf_pkg::ST_PREP;
            end
            mipf_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = mipf_pkg::ST_MUL2;
            end
            mipf_pkg::ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = mipf_pkg::ST_RND2;
            end
            mipf_pkg::ST_RND2: begin
                cmd.rnd2   = 1'b1;
                state_next = mipf_pkg::ST_CHECK;
            end
            mipf_pkg::ST_CHECK: begin
                if (status.close) begin
                    // value came back near the pass start: period found
                    cmd.end_close = 1'b1;
                    state_next    = mipf_pkg::ST_EMIT_RD;
                end else begin
                    cmd.store = 1'b1;
                    if (status.iter_done) begin
                        cmd.end_limit = 1'b1;
                        state_next    = mipf_pkg::ST_EMIT_RD;
                    end else begin
                        cmd.restart = status.pass_full;
                        state_next  = mipf_pkg::ST_MUL1;
                    end
                end
            end
            mipf_pkg::ST_EMIT_RD: begin
                cmd.rd     = 1'b1;
                state_next = mipf_pkg::ST_EMIT_LD;
            end
            mipf_pkg::ST_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.emit_last ? mipf_pkg::ST_IDLE
                                                    : mipf_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                state_next = mipf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/mipf_datapath.sv]
`timescale 1ns / 1ps
`include "map_iteration_period_finder_core_defines.svh"

module mipf_datapath #(
    parameter int STORE_DEPTH = mipf_pkg::STORE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [mipf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mipf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input payload
    input  logic signed [31:0]                  s_r_value,
    input  logic signed [31:0]                  s_x_start,
    // control
    input  mipf_pkg::cmd_t                      cmd,
    output mipf_pkg::status_t                   status,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_point,
    output logic [5:0]                          m_point_index,
    output logic [6:0]                          m_period_count,
    output logic                                m_last_point,
    output logic                                m_hit_limit
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int LEN_W = $clog2(STORE_DEPTH + 1);

    // Configuration registers
    logic        map_sel_reg;
    logic [6:0]  traj_len_reg;
    logic [27:0] iter_limit_reg;
    logic [27:0] tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_sel_reg    <= mipf_pkg::MAP_SELECT_RST;
            traj_len_reg   <= mipf_pkg::TRAJ_LEN_RST;
            iter_limit_reg <= mipf_pkg::ITER_LIMIT_RST;
            tol_reg        <= mipf_pkg::TOLERANCE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mipf_pkg::CFG_MAP_SELECT: map_sel_reg    <= cfg_wr_data[0];
                mipf_pkg::CFG_TRAJ_LEN:   traj_len_reg   <= cfg_wr_data[6:0];
                mipf_pkg::CFG_ITER_LIMIT: iter_limit_reg <= cfg_wr_data;
                mipf_pkg::CFG_TOLERANCE:  tol_reg        <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective pass length and step limit for a new item
    logic [LEN_W-1:0] len_eff;
    logic [27:0]      limit_eff;

    always_comb begin
        if (traj_len_reg == 7'd0) begin
            len_eff = LEN_W'(1);
        end else if (32'(traj_len_reg) > STORE_DEPTH) begin
            len_eff = LEN_W'(STORE_DEPTH);
        end else begin
            len_eff = LEN_W'(traj_len_reg);
        end
        limit_eff = (iter_limit_reg < 28'(len_eff)) ? 28'(len_eff) : iter_limit_reg;
    end

    // Control counters
    logic [LEN_W-1:0] len_reg;
    logic [27:0]      limit_reg;
    logic [27:0]      iter_reg;
    logic [LEN_W-1:0] j_reg;
    logic [LEN_W-1:0] k_reg;
    logic [LEN_W-1:0] n_reg;
    logic             hit_reg;
    logic [LEN_W-1:0] j_plus_one;

    assign j_plus_one = j_reg + LEN_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= LEN_W'(1);
            limit_reg <= 28'd1;
            iter_reg  <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            n_reg     <= LEN_W'(1);
            hit_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                len_reg   <= len_eff;
                limit_reg <= limit_eff;
                iter_reg  <= '0;
                j_reg     <= '0;
            end
            if (cmd.mul1) begin
                iter_reg <= iter_reg + 28'd1;
            end
            if (cmd.store) begin
                j_reg <= cmd.restart ? '0 : j_plus_one;
            end
            if (cmd.end_close) begin
                n_reg   <= j_reg;
                hit_reg <= 1'b0;
                k_reg   <= '0;
            end
            if (cmd.end_limit) begin
                n_reg   <= j_plus_one;
                hit_reg <= 1'b1;
                k_reg   <= '0;
            end
            if (cmd.out_load) begin
                k_reg <= k_reg + LEN_W'(1);
            end
        end
    end

    // Map arithmetic: one shared multiplier, two passes per step
    logic signed [31:0] r_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] first_reg;
    logic signed [31:0] q1_reg;
    logic signed [31:0] opa_reg;
    logic signed [31:0] opb_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    always_comb begin
        if (cmd.mul2) begin
            mul_a = opa_reg;
            mul_b = opb_reg;
        end else begin
            mul_a = map_sel_reg ? x_reg : r_reg;
            mul_b = x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            r_reg <= s_r_value;
            x_reg <= s_x_start;
        end
        if (cmd.mul1 || cmd.mul2) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.rnd1) begin
            q1_reg <= mipf_pkg::rnd_sat(prod_reg);
        end
        if (cmd.prep) begin
            // cubic: x * sat(r - x*x); logistic: (r*x) * sat(1 - x)
            opa_reg <= map_sel_reg ? x_reg : q1_reg;
            opb_reg <= map_sel_reg ? mipf_pkg::sat_sub(r_reg, q1_reg)
                                   : mipf_pkg::sat_sub(mipf_pkg::Q_ONE, x_reg);
        end
        if (cmd.rnd2) begin
            x_reg <= mipf_pkg::rnd_sat(prod_reg);
        end
        if (cmd.store && j_reg == '0) begin
            first_reg <= x_reg;
        end
    end

    // Closeness of the new value to the first value of the pass
    logic signed [32:0] diff;
    logic signed [32:0] tol_s;
    logic               close_raw;

    always_comb begin
        diff      = 33'(first_reg) - 33'(x_reg);
        tol_s     = $signed({5'b0, tol_reg});
        close_raw = diff[32] ? (diff > -tol_s) : (diff < tol_s);
    end

    // Trajectory store
    logic [31:0] mem [STORE_DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[j_reg[AW-1:0]] <= x_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[k_reg[AW-1:0]];
        end
    end

    // Output register
    logic             m_valid_reg;
    logic signed [31:0] point_reg;
    logic [LEN_W-1:0] out_k_reg;
    logic [LEN_W-1:0] out_n_reg;
    logic             out_last_reg;
    logic             out_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            point_reg    <= $signed(rdata_reg);
            out_k_reg    <= k_reg;
            out_n_reg    <= n_reg;
            out_last_reg <= status.emit_last;
            out_hit_reg  <= hit_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point        = point_reg;
    assign m_point_index  = 6'(out_k_reg);
    assign m_period_count = 7'(out_n_reg);
    assign m_last_point   = out_last_reg;
    assign m_hit_limit    = out_hit_reg;

    // Status back to the controller
    assign status.close     = close_raw && (j_reg != '0);
    assign status.iter_done = (iter_reg >= limit_reg);
    assign status.pass_full = (j_plus_one == len_reg);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.emit_last = (k_reg + LEN_W'(1) == n_reg);

    // Checks
    `MIPF_ASSERT_ALWAYS(a_store_in_pass, aclk, aresetn, !cmd.store || (j_reg < len_reg), "store write beyond pass length")
    `MIPF_ASSERT_ALWAYS(a_iter_bound, aclk, aresetn, iter_reg <= limit_reg, "step count passed the limit")
    `MIPF_ASSERT_ALWAYS(a_out_index, aclk, aresetn, !m_valid_reg || (out_k_reg < out_n_reg), "point index not below period count")
    `MIPF_ASSERT_NEXT(a_last_flag, aclk, aresetn, cmd.out_load, out_last_reg == (out_k_reg + LEN_W'(1) == out_n_reg), "last flag does not match count")

endmodule

[hdl/map_iteration_period_finder_core.sv]
`timescale 1ns / 1ps
// Period finder for the cubic or logistic map in signed Q4.28.
// Input channel s_*: one transaction carries r (s_r_value) and a start value
// (s_x_start). Result channel m_*: one transaction per stored trajectory point,
// with its index, the period count, a last flag and a limit flag.
// Configuration: write cfg_wr_data to register cfg_index with cfg_wr_en while
// the block is idle (0 map select, 1 pass length, 2 step limit, 3 tolerance).
// In each map step both multiplies go through one shared 32x32 multiplier,
// each followed by a rounding and saturation stage, then a closeness
// compare against the first point of the pass.
// Points are read from the trajectory memory one at a time into an output
// register; a stall on m_ready holds that register and pauses the readout.
// s_ready rises once the last point sits in the output register, so a new
// item may start while it waits to be taken.
// Reset (aresetn, synchronous, active low) restores register defaults and
// empties the output register; trajectory memory needs no clearing.
module map_iteration_period_finder_core #(
    parameter int STORE_DEPTH = mipf_pkg::STORE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mipf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mipf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [31:0]               s_r_value,
    input  logic signed [31:0]               s_x_start,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_point,
    output logic [5:0]                       m_point_index,
    output logic [6:0]                       m_period_count,
    output logic                             m_last_point,
    output logic                             m_hit_limit
);

    mipf_pkg::cmd_t    cmd;
    mipf_pkg::status_t status;

    // Sequencer
    mipf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, counters, trajectory memory and output register
    mipf_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_r_value      (s_r_value),
        .s_x_start      (s_x_start),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point        (m_point),
        .m_point_index  (m_point_index),
        .m_period_count (m_period_count),
        .m_last_point   (m_last_point),
        .m_hit_limit    (m_hit_limit)
    );

endmodule
